// ----- design/json_uint_field_extractor_top_defines.svh -----
// ----------------------------------------------------------------------------
// JSON uint field extractor assertion macros
// Concurrent check wrappers, compiled out for synthesis. They expect signals
// named clock and reset in the scope of use.
// ----------------------------------------------------------------------------
`ifndef JSON_UINT_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define JSON_UINT_FIELD_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define JUFE_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jufe: same-cycle check failed");
// next-cycle implication
`define JUFE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jufe: next-cycle check failed");
`else
`define JUFE_ASSERT_IMPLIES(lbl, ante, cons)
`define JUFE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/jufe_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON uint field extractor package
// Shared types, sizes and character codes.
// ----------------------------------------------------------------------------
package jufe_pkg;

   localparam int MAX_NAME_BYTES = 16;                  // 1..16
   localparam int NAME_REG_BYTES = 16;                  // bytes held by the two name regs
   localparam int NAME_IDX_W     = $clog2(NAME_REG_BYTES);
   localparam int WIN_DEPTH      = MAX_NAME_BYTES + 2;  // quote + name + quote
   localparam int LEN_W          = 5;
   localparam int VALUE_W        = 64;
   localparam int CSR_INDEX_W    = 2;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LO  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_HI  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LEN = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_NO_KEY   = 2'd0;
   localparam logic [1:0] STATUS_NO_COLON = 2'd1;
   localparam logic [1:0] STATUS_PARSED   = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] field_value;
      logic [1:0]         parse_status;
   } rsp_payload_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
      logic       key_hit;
   } queue_item_type;

endpackage

// ----- design/jufe_front.sv -----
// ----------------------------------------------------------------------------
// JSON uint field extractor front end
// Holds the name registers and the byte window; tags each byte with a
// quoted-key match and pushes it into the queue.
// ----------------------------------------------------------------------------
module jufe_front
   import jufe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_data,
   input  logic                   queue_full,
   output logic                   push_valid,
   output queue_item_type         push_item
);

   logic [VALUE_W-1:0] name_lo_ff;
   logic [VALUE_W-1:0] name_hi_ff;
   logic [LEN_W-1:0]   name_len_ff;

   logic [7:0]       window_ff [WIN_DEPTH];
   logic [7:0]       window_in [WIN_DEPTH];
   logic [LEN_W-1:0] fill_ff;
   logic [LEN_W-1:0] fill_in;

   logic [7:0]           name_arr [NAME_REG_BYTES];
   logic [LEN_W-1:0]     len;
   logic [LEN_W-1:0]     klen;
   logic [WIN_DEPTH-1:0] lane_ok;
   logic                 key_hit;
   logic                 accept;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept;

   always_comb begin
      logic [LEN_W-1:0]      e_w;
      logic [NAME_IDX_W-1:0] name_idx;
      logic [7:0]            want;
      for (int b = 0; b < NAME_REG_BYTES; b++) begin
         if (b < 8) begin
            name_arr[b] = name_lo_ff[8*b +: 8];
         end else begin
            name_arr[b] = name_hi_ff[8*(b-8) +: 8];
         end
      end
      len  = (name_len_ff > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES) : name_len_ff;
      klen = len + LEN_W'(2);
      // lane 0 is the newest byte
      window_in[0] = req_payload.line_byte;
      for (int e = 1; e < WIN_DEPTH; e++) begin
         window_in[e] = window_ff[e-1];
      end
      fill_in = (fill_ff < LEN_W'(WIN_DEPTH)) ? fill_ff + LEN_W'(1) : fill_ff;
      for (int e = 0; e < WIN_DEPTH; e++) begin
         e_w      = LEN_W'(e);
         name_idx = NAME_IDX_W'(len - e_w);
         if (e_w == '0 || e_w == klen - LEN_W'(1)) begin
            want = CHAR_QUOTE;
         end else begin
            want = name_arr[name_idx];
         end
         lane_ok[e] = (e_w >= klen) || (window_in[e] == want);
      end
      key_hit = (&lane_ok) && (fill_in >= klen);
   end

   assign push_item.line_byte = req_payload.line_byte;
   assign push_item.line_end  = req_payload.line_end;
   assign push_item.key_hit   = key_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_lo_ff  <= '0;
         name_hi_ff  <= '0;
         name_len_ff <= '0;
         fill_ff     <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_NAME_LO:  name_lo_ff  <= csr_data;
               CSR_NAME_HI:  name_hi_ff  <= csr_data;
               CSR_NAME_LEN: name_len_ff <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            fill_ff <= req_payload.line_end ? '0 : fill_in;
         end
      end
   end

   // window bytes beyond the fill count never count toward a key hit
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- design/jufe_queue.sv -----
// ----------------------------------------------------------------------------
// JSON uint field extractor queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "json_uint_field_extractor_top_defines.svh"

module jufe_queue
   import jufe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  queue_item_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           pop_valid,
   output queue_item_type pop_item
);

   queue_item_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         case ({push_valid, pop})
            2'b10:   count_ff <= count_ff + QUEUE_CNT_W'(1);
            2'b01:   count_ff <= count_ff - QUEUE_CNT_W'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `JUFE_ASSERT_IMPLIES(a_no_overflow, push_valid, !full)
   `JUFE_ASSERT_IMPLIES(a_no_underflow, pop, pop_valid)
   `JUFE_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

// ----- design/jufe_back.sv -----
// ----------------------------------------------------------------------------
// JSON uint field extractor back end
// Runs the colon / whitespace / digit sequence, accumulates the value and
// holds the result register.
// ----------------------------------------------------------------------------
`include "json_uint_field_extractor_top_defines.svh"

module jufe_back
   import jufe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  queue_item_type  pop_item,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SPACE,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type          phase_ff;
   phase_type          phase_in;
   logic [VALUE_W-1:0] acc_ff;
   logic [VALUE_W-1:0] acc_in;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;
   rsp_payload_type    rsp_payload_in;

   logic               out_free;
   logic               is_digit;
   logic               is_space;
   logic [7:0]         digit;
   logic [VALUE_W-1:0] acc_times_ten;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // bytes without a result never wait on the output side
   assign pop       = pop_valid && (!pop_item.line_end || out_free);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign is_digit      = pop_item.line_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_space      = pop_item.line_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   assign digit         = pop_item.line_byte - CHAR_ZERO;
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (pop_item.key_hit) phase_in = PH_COLON;
         end
         PH_COLON: begin
            if (pop_item.line_byte == CHAR_COLON) phase_in = PH_SPACE;
         end
         PH_SPACE, PH_DIGITS: begin
            if (phase_ff == PH_DIGITS || !is_space) begin
               if (is_digit) begin
                  phase_in = PH_DIGITS;
                  acc_in   = acc_times_ten + VALUE_W'(digit);
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: ;
      endcase

      case (phase_in)
         PH_SEARCH: begin
            rsp_payload_in.field_value  = '0;
            rsp_payload_in.parse_status = STATUS_NO_KEY;
         end
         PH_COLON: begin
            rsp_payload_in.field_value  = '0;
            rsp_payload_in.parse_status = STATUS_NO_COLON;
         end
         default: begin
            rsp_payload_in.field_value  = acc_in;
            rsp_payload_in.parse_status = STATUS_PARSED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (pop_item.line_end) begin
               phase_ff <= PH_SEARCH;
               acc_ff   <= '0;
            end else begin
               phase_ff <= phase_in;
               acc_ff   <= acc_in;
            end
         end
         if (pop && pop_item.line_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop && pop_item.line_end) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   `JUFE_ASSERT_NEXT(a_line_clears, pop && pop_item.line_end, phase_ff == PH_SEARCH && acc_ff == '0)
   `JUFE_ASSERT_IMPLIES(a_acc_idle, phase_ff == PH_SEARCH || phase_ff == PH_COLON || phase_ff == PH_SPACE, acc_ff == '0)
   `JUFE_ASSERT_IMPLIES(a_zero_unless_parsed, rsp_valid_ff && rsp_payload_ff.parse_status != STATUS_PARSED, rsp_payload_ff.field_value == '0)

endmodule

// ----- design/json_uint_field_extractor_top.sv -----
// Path: an accepted byte is registered into the queue; a line-end byte's result is
//   registered in the response register when the back pops it.
// Throughput: one byte per cycle while the queue is not full; the front window
//   compare and the back multiply-by-ten/add are combinational, a two-entry queue joins them.
// Reset (synchronous, active high) zeroes the name registers, the window fill,
//   the queue, the parse phase, the value and the response valid.
// ----------------------------------------------------------------------------
// JSON uint field extractor top level
// Streams one text line a byte per request, finds the first quoted occurrence
// of the configured name, then the next colon, skips whitespace and gathers a
// decimal value (mod 2^64). The line's last byte produces one response with
// the value and a status: key missing, colon missing, or parsed.
// ----------------------------------------------------------------------------
module json_uint_field_extractor_top
   import jufe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // byte requests
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   // one response per line
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   // register writes: name low word, name high word, name length
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_data
);

   logic           queue_full;
   logic           push_valid;
   queue_item_type push_item;
   logic           pop;
   logic           pop_valid;
   queue_item_type pop_item;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   // Front: window shift and key compare, every byte gets a key-hit tag.
   jufe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   // Queue: decouples the front from a stalled response port.
   jufe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // Back: parse sequence, accumulator and response register. Non-final
   // bytes drain even while a response waits.
   jufe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
